// ----- hdl/spl_pkg.sv -----
// shared types and codes of the sorted priority list
`timescale 1ns / 1ps

package spl_pkg;

	// command codes
	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	// back end sequencer states
	typedef enum logic {
		BK_IDLE  = 1'b0,
		BK_APPLY = 1'b1
	} bk_state_t;

	// field widths
	localparam int unsigned ID_W    = 16;
	localparam int unsigned KEY_W   = 32;
	localparam int unsigned COUNT_W = 5;

	// one command item
	typedef struct packed {
		op_t               cmd;
		logic [ID_W-1:0]   item_id;
		logic [KEY_W-1:0]  prio_key;
	} cmd_item_t;

	// one result item
	typedef struct packed {
		status_t             status;
		logic [COUNT_W-1:0]  entry_count;
		logic                head_valid;
		logic [ID_W-1:0]     head_id;
		logic [KEY_W-1:0]    head_key;
	} rsp_item_t;

	// queue head handed from front end to back end
	typedef struct packed {
		logic       valid;
		cmd_item_t  item;
	} queue_head_t;

endpackage

// ----- hdl/spl_front.sv -----
// front end: command acceptance and two-entry command queue
`timescale 1ns / 1ps

module spl_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cmd_valid,
	output logic                    cmd_ready,
	input  spl_pkg::cmd_item_t      cmd_data,
	output spl_pkg::queue_head_t    q_head,
	input  logic                    q_pop
);

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QCW    = $clog2(QDEPTH + 1);
	localparam int unsigned QPW    = $clog2(QDEPTH);

	spl_pkg::cmd_item_t  buf_q [QDEPTH];
	logic [QCW-1:0]      cnt_q;
	logic [QPW-1:0]      wr_ptr_q;
	logic [QPW-1:0]      rd_ptr_q;
	logic                push;
	logic                pop;

	// handshake decode
	assign cmd_ready = (cnt_q != QCW'(QDEPTH));
	assign push      = cmd_valid && cmd_ready;
	assign pop       = q_pop && q_head.valid;

	// queue head toward the back end
	assign q_head.valid = (cnt_q != '0);
	assign q_head.item  = buf_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCW'(1);
			end
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= cmd_data;
		end
	end

`ifndef SYNTHESIS
	// never more entries than slots
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCW'(QDEPTH))
		else $error("spl_front: queue count overflow");

	// a pop only ever happens with something queued
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_head.valid)
		else $error("spl_front: pop from empty queue");

	// read and write pointers differ by the fill count
	assert property (@(posedge clk) disable iff (!arst_n)
		QPW'(wr_ptr_q - rd_ptr_q) == QPW'(cnt_q))
		else $error("spl_front: pointer and count mismatch");
`endif

endmodule

// ----- hdl/spl_back.sv -----
// back end: sorted cell row, two-step command sequencer and result register
`timescale 1ns / 1ps

module spl_back #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  spl_pkg::queue_head_t    q_head,
	output logic                    q_pop,
	output logic                    rsp_valid,
	input  logic                    rsp_ready,
	output spl_pkg::rsp_item_t      rsp_data
);

	localparam int unsigned CW  = $clog2(DEPTH + 1);
	localparam int unsigned EW  = CW + spl_pkg::COUNT_W;
	localparam int unsigned IDW = spl_pkg::ID_W;
	localparam int unsigned KW  = spl_pkg::KEY_W;

	// list cells
	logic [IDW-1:0]      id_q  [DEPTH];
	logic [KW-1:0]       key_q [DEPTH];
	logic [DEPTH-1:0]    vld_q;
	logic [CW-1:0]       cnt_q;

	// sequencer and compare stage
	spl_pkg::bk_state_t  state_q;
	spl_pkg::bk_state_t  state_nxt;
	spl_pkg::cmd_item_t  item_s1;
	logic [DEPTH-1:0]    gt_s1;
	logic [DEPTH-1:0]    hit_s1;
	logic                apply;

	// update terms
	logic [DEPTH-1:0]    gt_now;
	logic [DEPTH-1:0]    hit_now;
	logic [DEPTH-1:0]    ins_at;
	logic [DEPTH-1:0]    hit_low;
	logic [DEPTH-1:0]    rm_from;
	logic                full;
	logic                found;
	logic                do_ins;
	logic                do_rm;
	logic [IDW-1:0]      id_nxt  [DEPTH];
	logic [KW-1:0]       key_nxt [DEPTH];
	logic [IDW-1:0]      id_lo   [DEPTH];
	logic [KW-1:0]       key_lo  [DEPTH];
	logic [IDW-1:0]      id_hi   [DEPTH];
	logic [KW-1:0]       key_hi  [DEPTH];
	logic [DEPTH-1:0]    vld_nxt;
	logic [CW-1:0]       cnt_nxt;
	logic [EW-1:0]       cnt_wide;
	spl_pkg::status_t    status_nxt;

	// result register
	logic                rsp_valid_q;
	spl_pkg::rsp_item_t  rsp_q;

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// per-cell compare against the queue head
	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cmp
			assign gt_now[g]  = !vld_q[g] || (key_q[g] > q_head.item.prio_key);
			assign hit_now[g] = vld_q[g] && (id_q[g] == q_head.item.item_id);
		end
	endgenerate

	// neighbor taps for the shift in either direction
	generate
		for (g = 0; g < DEPTH; g++) begin : g_tap
			if (g == 0) begin : g_lo_edge
				assign id_lo[g]  = '0;
				assign key_lo[g] = '0;
			end else begin : g_lo
				assign id_lo[g]  = id_q[g-1];
				assign key_lo[g] = key_q[g-1];
			end
			if (g == DEPTH - 1) begin : g_hi_edge
				assign id_hi[g]  = id_q[g];
				assign key_hi[g] = key_q[g];
			end else begin : g_hi
				assign id_hi[g]  = id_q[g+1];
				assign key_hi[g] = key_q[g+1];
			end
		end
	endgenerate

	// insert point is the rising edge of the thermometer, remove span starts at first hit
	assign ins_at  = gt_s1 & ~(gt_s1 << 1);
	assign hit_low = hit_s1 & (~hit_s1 + DEPTH'(1));
	assign rm_from = ~(hit_low - DEPTH'(1));
	assign full    = vld_q[DEPTH-1];
	assign found   = (hit_s1 != '0);
	assign do_ins  = (item_s1.cmd == spl_pkg::OP_INSERT) && !full;
	assign do_rm   = (item_s1.cmd == spl_pkg::OP_REMOVE) && found;

	// next cell contents
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			always_comb begin
				id_nxt[g]  = id_q[g];
				key_nxt[g] = key_q[g];
				if (do_ins) begin
					if (ins_at[g]) begin
						id_nxt[g]  = item_s1.item_id;
						key_nxt[g] = item_s1.prio_key;
					end else if (gt_s1[g]) begin
						id_nxt[g]  = id_lo[g];
						key_nxt[g] = key_lo[g];
					end
				end else if (do_rm && rm_from[g]) begin
					id_nxt[g]  = id_hi[g];
					key_nxt[g] = key_hi[g];
				end
			end
		end
	endgenerate

	// occupancy, count and status
	always_comb begin
		vld_nxt    = vld_q;
		cnt_nxt    = cnt_q;
		status_nxt = spl_pkg::ST_OK;
		if (item_s1.cmd == spl_pkg::OP_INSERT) begin
			if (full) begin
				status_nxt = spl_pkg::ST_FULL;
			end else begin
				vld_nxt = {vld_q[DEPTH-2:0], 1'b1};
				cnt_nxt = cnt_q + CW'(1);
			end
		end else begin
			if (!found) begin
				status_nxt = spl_pkg::ST_NOT_FOUND;
			end else begin
				vld_nxt = vld_q >> 1;
				cnt_nxt = cnt_q - CW'(1);
			end
		end
	end

	assign cnt_wide = EW'(cnt_nxt);

	// sequencer: take one command, then apply it once the result register is free
	always_comb begin
		state_nxt = state_q;
		q_pop     = 1'b0;
		apply     = 1'b0;
		case (state_q)
			spl_pkg::BK_IDLE: begin
				if (q_head.valid) begin
					q_pop     = 1'b1;
					state_nxt = spl_pkg::BK_APPLY;
				end
			end
			spl_pkg::BK_APPLY: begin
				if (!rsp_valid_q || rsp_ready) begin
					apply     = 1'b1;
					state_nxt = spl_pkg::BK_IDLE;
				end
			end
			default: begin
				state_nxt = spl_pkg::BK_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spl_pkg::BK_IDLE;
			vld_q       <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (apply) begin
				vld_q       <= vld_nxt;
				cnt_q       <= cnt_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// compare stage capture
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s1 <= q_head.item;
			gt_s1   <= gt_now;
			hit_s1  <= hit_now;
		end
	end

	// cell payload
	always_ff @(posedge clk) begin
		if (apply) begin
			for (int i = 0; i < DEPTH; i++) begin
				id_q[i]  <= id_nxt[i];
				key_q[i] <= key_nxt[i];
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (apply) begin
			rsp_q.status      <= status_nxt;
			rsp_q.entry_count <= cnt_wide[spl_pkg::COUNT_W-1:0];
			rsp_q.head_valid  <= vld_nxt[0];
			rsp_q.head_id     <= vld_nxt[0] ? id_nxt[0] : '0;
			rsp_q.head_key    <= vld_nxt[0] ? key_nxt[0] : '0;
		end
	end

`ifndef SYNTHESIS
	// count tracks the number of occupied cells
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == CW'($countones(vld_q)))
		else $error("spl_back: count does not match occupancy");

	// occupied cells form one run from the head
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q & (vld_q + DEPTH'(1))) == '0)
		else $error("spl_back: gap in occupied cells");

	// a popped command is always followed by its apply step
	assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q == spl_pkg::BK_APPLY))
		else $error("spl_back: pop without apply step");

	// the list changes only on an applied command
	assert property (@(posedge clk) disable iff (!arst_n)
		!$past(apply) |-> $stable(vld_q))
		else $error("spl_back: occupancy changed outside apply");
`endif

endmodule

// ----- hdl/sorted_priority_list_top.sv -----
// top level of the sorted priority list
//
//  channel  signals                        direction  carries
//  cmd      cmd_valid cmd_ready cmd_data   in         insert or remove command
//  rsp      rsp_valid rsp_ready rsp_data   out        status, count and head entry
//
// in the back end each command first has its key and id compared against every
// cell, then an apply step shifts the cell row and loads the result.
// a two-entry command queue lets new commands transfer while the back end is busy.
// a stalled result holds the back end in its apply step; the queue keeps accepting
// until full. reset clears occupancy, count, queue and handshake state.
`timescale 1ns / 1ps

module sorted_priority_list_top #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  spl_pkg::cmd_item_t    cmd_data,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output spl_pkg::rsp_item_t    rsp_data
);

	spl_pkg::queue_head_t  q_head;
	logic                  q_pop;

	// command intake and queue
	spl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_data  (cmd_data),
		.q_head    (q_head),
		.q_pop     (q_pop)
	);

	// sorted list and result
	spl_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

endmodule
